/* src/he1d_pkg.sv */
// Shared types and constants of the one-dimensional explicit heat equation step block.
package he1d_pkg;

    // Fixed field widths.
    localparam int POS_W      = 6;
    localparam int RATIO_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Defaults for the top level parameters.
    localparam int DEFAULT_MAX_NODES   = 64;
    localparam int DEFAULT_SAMPLE_BITS = 24;

    // Largest interior node count for which the last row position still fits in POS_W bits.
    localparam int MAX_INTERIOR = (2 ** POS_W) - 2;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Fixed-point rounding of the ratio product (ratio is unsigned Q0.16, held in 15 bits).
    localparam int FRAC_BITS  = 16;
    localparam int ROUND_HALF = 2 ** (FRAC_BITS - 1);

    // Register reset values.
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(8192);
    localparam logic [POS_W-1:0]   NODES_RESET = POS_W'(62);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_RATIO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_NODES  = CFG_IDX_W'(1);

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Decoded request as it travels from the front to the back.
    typedef struct packed {
        logic             is_step;
        logic             in_range;
        logic [POS_W-1:0] addr;
    } cmd_ctrl_t;

endpackage

/* src/he1d_queue.sv */
// Short first-in first-out queue between the request front and the execution back.
module he1d_queue
    import he1d_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/he1d_front.sv */
// Request front: accepts input requests, tracks the load position and decodes each request.
module he1d_front
    import he1d_pkg::*;
#(
    parameter int MAX_NODES   = DEFAULT_MAX_NODES,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          accept_en,
    input  logic [POS_W-1:0]              row_last,
    input  logic                          q_full,
    output logic                          q_push,
    output cmd_ctrl_t                     q_ctrl,
    output logic signed [SAMPLE_BITS-1:0] q_sample
);

    logic [POS_W-1:0] load_pos_reg, load_pos_next;
    logic [POS_W:0]   load_pos_inc;

    assign s_ready  = accept_en && !q_full;
    assign q_push   = s_valid && s_ready;
    assign q_sample = s_sample;

    always_comb begin
        q_ctrl.is_step  = (s_command == CMD_STEP);
        q_ctrl.in_range = (32'(load_pos_reg) < MAX_NODES);
        q_ctrl.addr     = load_pos_reg;
    end

    // The position wraps to zero once it passes the right boundary of the row.
    always_comb begin
        load_pos_inc  = {1'b0, load_pos_reg} + (POS_W + 1)'(1);
        load_pos_next = load_pos_reg;
        if (q_push && (s_command == CMD_LOAD)) begin
            load_pos_next = (load_pos_inc > {1'b0, row_last}) ? '0 : load_pos_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg <= '0;
        end else begin
            load_pos_reg <= load_pos_next;
        end
    end

endmodule

/* src/he1d_back.sv */
// Execution back: row memory, reset clearing pass, load writes and the pipelined row sweep.
module he1d_back
    import he1d_pkg::*;
#(
    parameter int MAX_NODES   = DEFAULT_MAX_NODES,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  cmd_ctrl_t                     q_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] q_sample,
    input  logic [RATIO_W-1:0]            ratio,
    input  logic [POS_W-1:0]              row_last,
    output logic                          clearing,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_temperature,
    output logic [POS_W-1:0]              m_node_index,
    output logic                          m_row_end
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = POS_W + 1;
    localparam int DW = SAMPLE_BITS + 2;
    localparam int PW = DW + RATIO_W + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_NODES];

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          issue_reg, issue_next;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0] sweep_end;
    logic [AW-1:0] rd_addr;
    logic          adv;

    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic signed [SAMPLE_BITS-1:0] mem_wd;

    // Pipeline stages of the sweep.
    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CW-1:0]                 k1_reg, k2_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] wl_reg, wc_reg, wr_reg;
    logic signed [DW-1:0]          d3_reg;
    logic signed [SAMPLE_BITS-1:0] c3_reg, c4_reg;
    logic [POS_W-1:0]              j3_reg, j4_reg;
    logic                          zero3_reg, zero4_reg;
    logic                          end3_reg, end4_reg;
    logic signed [PW-1:0]          prod4_reg;
    logic signed [PW-1:0]          rounded;
    logic signed [PW-1:0]          scaled;
    logic signed [SAMPLE_BITS-1:0] new_value;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_temp_reg;
    logic [POS_W-1:0]              out_idx_reg;
    logic                          out_end_reg;

    assign adv       = !out_valid_reg || m_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign clearing  = (state_reg == ST_CLEAR);
    assign sweep_end = CW'(row_last) + CW'(1);
    assign rd_addr   = (32'(rd_cnt_reg) < MAX_NODES) ? AW'(rd_cnt_reg) : '0;

    assign rounded   = prod4_reg + PW'(ROUND_HALF);
    assign scaled    = rounded >>> FRAC_BITS;
    assign new_value = zero4_reg ? '0 : c4_reg + SAMPLE_BITS'(scaled);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        issue_next   = issue_reg;
        rd_cnt_next  = rd_cnt_reg;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_wa       = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_pop && q_ctrl.is_step) begin
                    state_next  = ST_STEP;
                    issue_next  = 1'b1;
                    rd_cnt_next = '0;
                end else if (q_pop && q_ctrl.in_range) begin
                    mem_we = 1'b1;
                    mem_wa = AW'(q_ctrl.addr);
                    mem_wd = q_sample;
                end
            end
            ST_STEP: begin
                if (adv && issue_reg) begin
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                    if (rd_cnt_reg == sweep_end) begin
                        issue_next = 1'b0;
                    end
                end
                if (adv && v4_reg) begin
                    mem_we = 1'b1;
                    mem_wa = AW'(j4_reg);
                    mem_wd = new_value;
                    if (end4_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            issue_reg     <= 1'b0;
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            issue_reg   <= issue_next;
            rd_cnt_reg  <= rd_cnt_next;
            if (adv) begin
                v1_reg        <= issue_reg;
                v2_reg        <= v1_reg && (k1_reg != '0);
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                out_valid_reg <= v4_reg;
            end
        end
    end

    // Row memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (adv && issue_reg) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Window of three old values, then difference, product and final sum.
    always_ff @(posedge aclk) begin
        if (adv) begin
            k1_reg <= rd_cnt_reg;
            if (v1_reg) begin
                wl_reg <= wc_reg;
                wc_reg <= wr_reg;
                wr_reg <= rd_data_reg;
            end
            k2_reg    <= k1_reg;
            d3_reg    <= DW'(wl_reg) + DW'(wr_reg) - (DW'(wc_reg) <<< 1);
            c3_reg    <= wc_reg;
            j3_reg    <= POS_W'(k2_reg - CW'(1));
            zero3_reg <= (k2_reg == CW'(1)) || (k2_reg == sweep_end);
            end3_reg  <= (k2_reg == sweep_end);
            prod4_reg <= $signed({1'b0, ratio}) * d3_reg;
            c4_reg    <= c3_reg;
            j4_reg    <= j3_reg;
            zero4_reg <= zero3_reg;
            end4_reg  <= end3_reg;
            if (v4_reg) begin
                out_temp_reg <= new_value;
                out_idx_reg  <= j4_reg;
                out_end_reg  <= end4_reg;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_temperature = out_temp_reg;
    assign m_node_index  = out_idx_reg;
    assign m_row_end     = out_end_reg;

    a_result_from_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_STEP))
        else $error("result appeared outside a row sweep");

    a_idle_pipeline_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(issue_reg || v1_reg || v2_reg || v3_reg || v4_reg))
        else $error("sweep pipeline not empty in idle");

    a_row_end_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && end4_reg) |-> (j4_reg == row_last))
        else $error("row end mark on the wrong node");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!out_valid_reg && !q_pop))
        else $error("activity during the clearing pass");

endmodule

/* src/heat_equation_1d_explicit_step.sv */
// Top level of the one-dimensional explicit heat equation step block.
// This block keeps one row of temperatures (left boundary, interior nodes, right boundary)
// in an on-chip memory and advances it by explicit forward-time centred-space steps.
// A load request (command 0) writes its sample at the current load position, which then
// advances and wraps to zero after the right boundary. A step request (command 1) replaces
// every interior node by r*left + (1-2r)*centre + r*right of the old row, rounded to nearest
// with ties upward, forces both boundaries to zero and emits the whole new row left to right,
// one result per node, with row_end set on the last node. After reset the memory is cleared
// one entry per cycle, and no request is accepted during the clearing pass. A load request
// is written into the memory as it leaves the queue. A row holds interior_nodes + 2 nodes.
// A step is paced by the single read port of the row memory, which delivers one old value
// per cycle, while the result side does not stall, to the five-stage sweep pipeline. A
// two-entry queue sits between the request side and the execution side, so up to two
// requests can be taken while a sweep runs. The result leaves through a registered output
// stage; while a result waits to be taken, the whole sweep pipeline holds, so a result
// stall lengthens the step. Configuration writes (index 0: diffusion ratio, index 1:
// interior node count) take effect at once and must only be issued while the block is idle.
module heat_equation_1d_explicit_step
    import he1d_pkg::*;
#(
    parameter int MAX_NODES   = DEFAULT_MAX_NODES,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // Input request channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_temperature,
    output logic [POS_W-1:0]              m_node_index,
    output logic                          m_row_end
);

    localparam int NODE_LIMIT = (MAX_NODES - 2 < MAX_INTERIOR) ? MAX_NODES - 2 : MAX_INTERIOR;
    localparam int QW         = $bits(cmd_ctrl_t) + SAMPLE_BITS;

    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [POS_W-1:0]   nodes_reg, nodes_next;
    logic [POS_W-1:0]   nodes_active;
    logic [POS_W-1:0]   row_last;

    logic                          clearing;
    logic                          q_full;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_not_empty;
    cmd_ctrl_t                     front_ctrl;
    logic signed [SAMPLE_BITS-1:0] front_sample;
    logic [QW-1:0]                 q_out;
    cmd_ctrl_t                     back_ctrl;
    logic signed [SAMPLE_BITS-1:0] back_sample;

    // Configuration registers. Unknown indexes are ignored.
    always_comb begin
        ratio_next = ratio_reg;
        nodes_next = nodes_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIFFUSION_RATIO: ratio_next = cfg_data[RATIO_W-1:0];
                REG_INTERIOR_NODES:  nodes_next = cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RESET;
            nodes_reg <= NODES_RESET;
        end else begin
            ratio_reg <= ratio_next;
            nodes_reg <= nodes_next;
        end
    end

    // A count of zero acts as one interior node, and the count is capped so that the
    // whole row, boundaries included, fits in the memory.
    always_comb begin
        if (nodes_reg == '0) begin
            nodes_active = POS_W'(1);
        end else if (nodes_reg > POS_W'(NODE_LIMIT)) begin
            nodes_active = POS_W'(NODE_LIMIT);
        end else begin
            nodes_active = nodes_reg;
        end
        row_last = nodes_active + POS_W'(1);
    end

    he1d_front #(
        .MAX_NODES  (MAX_NODES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_command(s_command),
        .s_sample (s_sample),
        .accept_en(!clearing),
        .row_last (row_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ctrl   (front_ctrl),
        .q_sample (front_sample)
    );

    he1d_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({front_ctrl, front_sample}),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_out),
        .not_empty(q_not_empty)
    );

    assign back_ctrl   = q_out[QW-1:SAMPLE_BITS];
    assign back_sample = q_out[SAMPLE_BITS-1:0];

    he1d_back #(
        .MAX_NODES  (MAX_NODES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_not_empty),
        .q_pop        (q_pop),
        .q_ctrl       (back_ctrl),
        .q_sample     (back_sample),
        .ratio        (ratio_reg),
        .row_last     (row_last),
        .clearing     (clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_temperature(m_temperature),
        .m_node_index (m_node_index),
        .m_row_end    (m_row_end)
    );

endmodule
